// File: sv/tbtm_pkg.sv
// ----------------------------------------------------------------------------
// tbtm_pkg
// Shared types, constants and helpers of the token budget tag monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package tbtm_pkg;

  localparam int unsigned TOK_W   = 18;
  localparam int unsigned TAG_MAX = 3;              // tokens a pattern register holds
  localparam int unsigned PAT_W   = TOK_W * TAG_MAX;
  localparam int unsigned CNT_W   = 24;
  localparam int unsigned BIAS_W  = 16;
  localparam int unsigned LEN_W   = 2;
  localparam int unsigned IDX_W   = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [0:0] {
    CMD_TOKEN = 1'b0,
    CMD_QUERY = 1'b1
  } tbtm_cmd_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_FORCE = 2'd1,
    ACT_BIAS  = 2'd2
  } tbtm_action_e;

  typedef enum logic [IDX_W-1:0] {
    REG_TOKEN_BUDGET  = 3'd0,
    REG_HARD_MODE     = 3'd1,
    REG_BIAS_AMOUNT   = 3'd2,
    REG_OPEN_LENGTH   = 3'd3,
    REG_OPEN_PATTERN  = 3'd4,
    REG_CLOSE_LENGTH  = 3'd5,
    REG_CLOSE_PATTERN = 3'd6
  } tbtm_reg_e;

  // Register values the controller needs
  typedef struct packed {
    logic [CNT_W-1:0]         budget;
    logic                     hard;
    logic signed [BIAS_W-1:0] bias;
    logic [LEN_W-1:0]         close_len;
    logic [PAT_W-1:0]         close_pat;
  } tbtm_cfg_t;

  // Per-cell compare results, bit l stands for a tag of length l+1
  typedef struct packed {
    logic [TAG_MAX-1:0] open_hit;
    logic [TAG_MAX-1:0] close_hit;
  } tbtm_match_t;

  // Tag token at a position; a position past the pattern reads as zero
  function automatic logic [TOK_W-1:0] tag_token(logic [PAT_W-1:0] pat,
                                                 logic [LEN_W-1:0] pos);
    logic [TOK_W-1:0] tok;
    case (pos)
      2'd0:    tok = pat[TOK_W-1:0];
      2'd1:    tok = pat[2*TOK_W-1:TOK_W];
      2'd2:    tok = pat[3*TOK_W-1:2*TOK_W];
      default: tok = '0;
    endcase
    return tok;
  endfunction

endpackage

`default_nettype wire

// File: sv/tbtm_cell.sv
// ----------------------------------------------------------------------------
// tbtm_cell
// One slot of the recent-token window: holds a word, passes it on to the
// next slot on every shift and compares the arriving word with both tags.
// ----------------------------------------------------------------------------
`default_nettype none

module tbtm_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        shift_i,
  input  wire logic [tbtm_pkg::TOK_W-1:0]  tok_i,
  input  wire logic                        vld_i,
  input  wire logic [tbtm_pkg::PAT_W-1:0]  open_pat_i,
  input  wire logic [tbtm_pkg::PAT_W-1:0]  close_pat_i,
  output logic [tbtm_pkg::TOK_W-1:0]       tok_o,
  output logic                             vld_o,
  output tbtm_pkg::tbtm_match_t            match_o
);
  import tbtm_pkg::*;

  logic [TOK_W-1:0] tok_q;
  logic             vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      tok_q <= tok_i;
    end
  end

  // Slot IDX of a window that ends with a tag of length l+1 holds tag token l-IDX.
  // Slots beyond the tag length answer 1 so they drop out of the AND.
  always_comb begin
    for (int l = 0; l < int'(TAG_MAX); l++) begin
      if (l < int'(IDX)) begin
        match_o.open_hit[l]  = 1'b1;
        match_o.close_hit[l] = 1'b1;
      end else begin
        match_o.open_hit[l]  = vld_i && (tok_i == tag_token(open_pat_i, LEN_W'(l - int'(IDX))));
        match_o.close_hit[l] = vld_i &&
                               (tok_i == tag_token(close_pat_i, LEN_W'(l - int'(IDX))));
      end
    end
  end

  assign tok_o = tok_q;
  assign vld_o = vld_q;

endmodule

`default_nettype wire

// File: sv/tbtm_ctrl.sv
// ----------------------------------------------------------------------------
// tbtm_ctrl
// Section flag, saturating token counter, forced closing sequence and the
// registered result stage with its handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module tbtm_ctrl (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              command_i,
  input  wire logic [tbtm_pkg::TOK_W-1:0]        token_in_i,
  input  wire tbtm_pkg::tbtm_cfg_t               cfg_i,
  input  wire logic                              open_match_i,
  input  wire logic                              close_match_i,
  output logic                                   shift_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [1:0]                             action_o,
  output logic [tbtm_pkg::TOK_W-1:0]             token_out_o,
  output logic signed [tbtm_pkg::BIAS_W-1:0]     bias_out_o,
  output logic                                   in_section_o,
  output logic [tbtm_pkg::CNT_W-1:0]             tokens_used_o
);
  import tbtm_pkg::*;

  logic             accept;
  logic             inside_q, inside_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [LEN_W-1:0] fidx_q, fidx_d;
  logic [LEN_W-1:0] fleft_q, fleft_d;

  tbtm_action_e      act;
  logic [TOK_W-1:0]  tok_res;
  logic signed [BIAS_W-1:0] bias_res;

  logic                     out_valid_q;
  tbtm_action_e             out_action_q;
  logic [TOK_W-1:0]         out_token_q;
  logic signed [BIAS_W-1:0] out_bias_q;
  logic                     out_inside_q;
  logic [CNT_W-1:0]         out_used_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign shift_o    = accept && (command_i == CMD_TOKEN);

  always_comb begin
    inside_d = inside_q;
    used_d   = used_q;
    fidx_d   = fidx_q;
    fleft_d  = fleft_q;
    act      = ACT_NONE;
    tok_res  = '0;
    bias_res = '0;
    if (command_i == CMD_TOKEN) begin
      // Advance the forced sequence on a matching word
      if (fleft_q != '0 && token_in_i == tag_token(cfg_i.close_pat, fidx_q)) begin
        fidx_d  = fidx_q + 2'd1;
        fleft_d = fleft_q - 2'd1;
      end
      if (!inside_q) begin
        if (open_match_i) begin
          inside_d = 1'b1;
          used_d   = '0;
          fidx_d   = '0;
          fleft_d  = '0;
        end
      end else if (close_match_i) begin
        inside_d = 1'b0;
        used_d   = '0;
        fidx_d   = '0;
        fleft_d  = '0;
      end else if (used_q != CNT_MAX) begin
        used_d = used_q + 1'b1;
      end
    end else if (inside_q && cfg_i.budget != '0 && used_q >= cfg_i.budget) begin
      if (cfg_i.hard) begin
        if (fleft_q == '0) begin
          fidx_d  = '0;
          fleft_d = cfg_i.close_len;
        end
        if (fleft_d != '0) begin
          act     = ACT_FORCE;
          tok_res = tag_token(cfg_i.close_pat, fidx_d);
        end
      end else if (cfg_i.close_len != '0) begin
        act      = ACT_BIAS;
        tok_res  = tag_token(cfg_i.close_pat, 2'd0);
        bias_res = cfg_i.bias;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q    <= 1'b0;
      used_q      <= '0;
      fidx_q      <= '0;
      fleft_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        inside_q <= inside_d;
        used_q   <= used_d;
        fidx_q   <= fidx_d;
        fleft_q  <= fleft_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_action_q <= act;
      out_token_q  <= tok_res;
      out_bias_q   <= bias_res;
      out_inside_q <= inside_d;
      out_used_q   <= used_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = out_action_q;
  assign token_out_o   = out_token_q;
  assign bias_out_o    = out_bias_q;
  assign in_section_o  = out_inside_q;
  assign tokens_used_o = out_used_q;

`ifndef SYNTHESIS
  a_force_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fleft_q != '0 |-> inside_q)
    else $error("forced sequence pending outside a section");

  a_token_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CMD_TOKEN) |=> (out_valid_q && out_action_q == ACT_NONE))
    else $error("token word produced an action");

  a_force_in_section: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_action_q == ACT_FORCE) |-> out_inside_q)
    else $error("force reported outside a section");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_action_q == ACT_NONE) |-> (out_token_q == '0 && out_bias_q == '0))
    else $error("idle action carries a token or bias");
`endif

endmodule

`default_nettype wire

// File: sv/token_budget_tag_monitor.sv
// Result: a result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle; the window cells, tag compare and counter
// update all settle in the accepting cycle, and the input stalls only while a
// finished word waits in the result register on a stalled output.
// Reset: asynchronous, active low; clears the window, section, counter and
// forced sequence, and loads all registers with zero except hard_mode = 1.
// ----------------------------------------------------------------------------
// token_budget_tag_monitor
// Tracks tag-delimited sections in a token stream, counts tokens inside and
// answers queries with a force or bias toward the closing tag.
// ----------------------------------------------------------------------------
`default_nettype none

module token_budget_tag_monitor #(
  parameter int unsigned MAX_TAG = 3
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [tbtm_pkg::IDX_W-1:0]        cfg_index_i,
  input  wire logic [tbtm_pkg::PAT_W-1:0]        cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              command_i,
  input  wire logic [tbtm_pkg::TOK_W-1:0]        token_in_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [1:0]                             action_o,
  output logic [tbtm_pkg::TOK_W-1:0]             token_out_o,
  output logic signed [tbtm_pkg::BIAS_W-1:0]     bias_out_o,
  output logic                                   in_section_o,
  output logic [tbtm_pkg::CNT_W-1:0]             tokens_used_o
);
  import tbtm_pkg::*;

  logic [CNT_W-1:0]         budget_q;
  logic                     hard_q;
  logic signed [BIAS_W-1:0] bias_q;
  logic [LEN_W-1:0]         open_len_q;
  logic [PAT_W-1:0]         open_pat_q;
  logic [LEN_W-1:0]         close_len_q;
  logic [PAT_W-1:0]         close_pat_q;

  tbtm_cfg_t   cfg;
  tbtm_match_t hits [MAX_TAG];
  logic [TOK_W-1:0] chain_tok [MAX_TAG+1];
  logic             chain_vld [MAX_TAG+1];
  logic             shift;
  logic [TAG_MAX-1:0] open_all, close_all;
  logic             open_match, close_match;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q    <= '0;
      hard_q      <= 1'b1;
      bias_q      <= '0;
      open_len_q  <= '0;
      open_pat_q  <= '0;
      close_len_q <= '0;
      close_pat_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TOKEN_BUDGET:  budget_q    <= cfg_data_i[CNT_W-1:0];
        REG_HARD_MODE:     hard_q      <= cfg_data_i[0];
        REG_BIAS_AMOUNT:   bias_q      <= cfg_data_i[BIAS_W-1:0];
        REG_OPEN_LENGTH:   open_len_q  <= cfg_data_i[LEN_W-1:0];
        REG_OPEN_PATTERN:  open_pat_q  <= cfg_data_i;
        REG_CLOSE_LENGTH:  close_len_q <= cfg_data_i[LEN_W-1:0];
        REG_CLOSE_PATTERN: close_pat_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg.budget    = budget_q;
  assign cfg.hard      = hard_q;
  assign cfg.bias      = bias_q;
  assign cfg.close_len = close_len_q;
  assign cfg.close_pat = close_pat_q;

  // Newest word enters cell 0 and is always valid
  assign chain_tok[0] = token_in_i;
  assign chain_vld[0] = 1'b1;

  for (genvar j = 0; j < MAX_TAG; j++) begin : g_cell
    tbtm_cell #(.IDX(j)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (shift),
      .tok_i       (chain_tok[j]),
      .vld_i       (chain_vld[j]),
      .open_pat_i  (open_pat_q),
      .close_pat_i (close_pat_q),
      .tok_o       (chain_tok[j+1]),
      .vld_o       (chain_vld[j+1]),
      .match_o     (hits[j])
    );
  end

  // AND the cell answers per tag length; a tag longer than the window never hits
  always_comb begin
    for (int l = 0; l < int'(TAG_MAX); l++) begin
      open_all[l]  = (l < int'(MAX_TAG));
      close_all[l] = (l < int'(MAX_TAG));
      for (int j = 0; j < int'(MAX_TAG); j++) begin
        open_all[l]  = open_all[l] & hits[j].open_hit[l];
        close_all[l] = close_all[l] & hits[j].close_hit[l];
      end
    end
  end

  assign open_match  = (open_len_q != '0) && open_all[open_len_q - 2'd1];
  assign close_match = (close_len_q != '0) && close_all[close_len_q - 2'd1];

  tbtm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .token_in_i    (token_in_i),
    .cfg_i         (cfg),
    .open_match_i  (open_match),
    .close_match_i (close_match),
    .shift_o       (shift),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .action_o      (action_o),
    .token_out_o   (token_out_o),
    .bias_out_o    (bias_out_o),
    .in_section_o  (in_section_o),
    .tokens_used_o (tokens_used_o)
  );

endmodule

`default_nettype wire
